// ----- src/assert_macros.svh -----
// Assertion macros for the optics combiner RTL.
// Included by files that carry concurrent checks; empty in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TSOC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TSOC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define TSOC_ASSERT(lbl, prop, msg)
`define TSOC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ----- src/tsoc_pkg.sv -----
// Shared types and constants for the two-stream optics combiner.
// No dependencies.
package tsoc_pkg;

  localparam logic [15:0] ALB_ONE  = 16'd32768;
  localparam logic [15:0] ASYM_MAX = 16'd32767;
  localparam int unsigned QW       = 16;
  localparam int unsigned DIV_FST  = 3;
  localparam int unsigned NUM_STG  = DIV_FST + QW + 1;

  typedef struct packed {
    logic        match;
    logic        last;
    logic        neg;
    logic [31:0] depth;
    logic [15:0] p_alb;
    logic [15:0] p_asym;
  } side_t;

  typedef struct packed {
    logic [47:0] alb_rem;
    logic [32:0] alb_div;
    logic [15:0] alb_q;
    logic [62:0] asy_rem;
    logic [47:0] asy_div;
    logic [15:0] asy_q;
  } div_t;

  function automatic logic [15:0] clamp_alb(input logic [15:0] a);
    clamp_alb = (a > ALB_ONE) ? ALB_ONE : a;
  endfunction

endpackage

// ----- src/tsoc_div_stage.sv -----
// One quotient bit of both restoring dividers, registered.
// Depends on tsoc_pkg.
module tsoc_div_stage import tsoc_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [3:0] step_i,
  input  div_t       div_i,
  input  side_t      side_i,
  output div_t       div_o,
  output side_t      side_o
);

  div_t        div_d;
  div_t        div_q;
  side_t       side_q;
  logic [48:0] alb_sh;
  logic [63:0] asy_sh;
  logic [15:0] bit_m;

  always_comb begin
    div_d  = div_i;
    bit_m  = 16'd1 << step_i;
    alb_sh = {16'b0, div_i.alb_div} << step_i;
    asy_sh = {16'b0, div_i.asy_div} << step_i;
    if ({1'b0, div_i.alb_rem} >= alb_sh) begin
      div_d.alb_rem = div_i.alb_rem - alb_sh[47:0];
      div_d.alb_q   = div_i.alb_q | bit_m;
    end
    if ({1'b0, div_i.asy_rem} >= asy_sh) begin
      div_d.asy_rem = div_i.asy_rem - asy_sh[62:0];
      div_d.asy_q   = div_i.asy_q | bit_m;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q  <= div_d;
      side_q <= side_i;
    end
  end

  assign div_o  = div_q;
  assign side_o = side_q;

endmodule

// ----- src/two_stream_optics_combine_top.sv -----
// Two-stream optics combiner, top level.
// Depends on tsoc_pkg, tsoc_div_stage and assert_macros.svh.
//
// Input channel valid_i/stall_o carries one cell's point and band optics;
// output channel valid_o/stall_i returns the combined depth, albedo and
// asymmetry, one result per input transaction, in order.
// Throughput is one transaction per cycle while stall_i is low: stages
// 0-1 form the weighted scattering products, stage 2 the numerators and
// floored divisors, stages 3-18 resolve one quotient bit each of the two
// dividers, stage 19 clamps and selects the pass-through case.
// Each stage holds its own valid bit; a stalled output holds its result
// and empty stages behind it keep filling, so stall_o rises only when all
// 20 stages are occupied and stall_i is high.
// Reset clears all valid bits; the pipeline is empty afterward.
`include "assert_macros.svh"
module two_stream_optics_combine_top import tsoc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [31:0]        point_depth_i,
  input  logic [15:0]        point_albedo_i,
  input  logic signed [15:0] point_asym_i,
  input  logic [31:0]        band_depth_i,
  input  logic [15:0]        band_albedo_i,
  input  logic signed [15:0] band_asym_i,
  input  logic               band_match_i,
  input  logic               last_item_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [31:0]        sum_depth_o,
  output logic [15:0]        sum_albedo_o,
  output logic signed [15:0] sum_asym_o,
  output logic               last_out_o
);

  logic [NUM_STG-1:0] v_q;
  logic [NUM_STG-1:0] v_in;
  logic [NUM_STG-1:0] en;

  always_comb begin
    en[NUM_STG-1] = !v_q[NUM_STG-1] || !stall_i;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign stall_o = !en[0];
  assign v_in    = {v_q[NUM_STG-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // stage 0: scattering depths and depth sum
  logic [32:0]        tsum_a;
  logic [46:0]        s1_q, s2_q;
  logic [32:0]        tsum_q;
  logic signed [15:0] a1_q, a2_q;
  side_t              side_a_d, side_a_q;

  always_comb begin
    tsum_a          = {1'b0, point_depth_i} + {1'b0, band_depth_i};
    side_a_d.match  = band_match_i;
    side_a_d.last   = last_item_i;
    side_a_d.neg    = 1'b0;
    side_a_d.p_alb  = point_albedo_i;
    side_a_d.p_asym = point_asym_i;
    if (!band_match_i) begin
      side_a_d.depth = point_depth_i;
    end else if (tsum_a[32]) begin
      side_a_d.depth = '1;
    end else begin
      side_a_d.depth = tsum_a[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_q     <= {15'b0, point_depth_i} * clamp_alb(point_albedo_i);
      s2_q     <= {15'b0, band_depth_i} * clamp_alb(band_albedo_i);
      tsum_q   <= tsum_a;
      a1_q     <= point_asym_i;
      a2_q     <= band_asym_i;
      side_a_q <= side_a_d;
    end
  end

  // stage 1: total scattering and asymmetry products
  logic [47:0]        s_q;
  logic signed [62:0] p1_q, p2_q;
  logic [32:0]        tsum_b_q;
  side_t              side_b_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s_q      <= {1'b0, s1_q} + {1'b0, s2_q};
      p1_q     <= $signed({16'b0, s1_q}) * a1_q;
      p2_q     <= $signed({16'b0, s2_q}) * a2_q;
      tsum_b_q <= tsum_q;
      side_b_q <= side_a_q;
    end
  end

  // stage 2: numerator magnitude and floored divisors
  logic signed [63:0] num_c;
  logic [63:0]        mag_c;
  div_t               div_c_d, div_c_q;
  side_t              side_c_d, side_c_q;

  always_comb begin
    num_c            = 64'(p1_q) + 64'(p2_q);
    mag_c            = num_c[63] ? 64'(-num_c) : 64'(num_c);
    side_c_d         = side_b_q;
    side_c_d.neg     = num_c[63];
    div_c_d.alb_rem  = s_q;
    div_c_d.alb_div  = (tsum_b_q == '0) ? 33'd1 : tsum_b_q;
    div_c_d.alb_q    = '0;
    div_c_d.asy_rem  = mag_c[62:0];
    div_c_d.asy_div  = (s_q == '0) ? 48'd1 : s_q;
    div_c_d.asy_q    = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      div_c_q  <= div_c_d;
      side_c_q <= side_c_d;
    end
  end

  // stages 3..18: one quotient bit each
  div_t  div_w  [QW+1];
  side_t side_w [QW+1];

  assign div_w[0]  = div_c_q;
  assign side_w[0] = side_c_q;

  for (genvar j = 0; j < QW; j++) begin : g_div
    tsoc_div_stage u_stage (
      .clk_i  (clk_i),
      .en_i   (en[DIV_FST+j]),
      .step_i (4'(QW - 1 - j)),
      .div_i  (div_w[j]),
      .side_i (side_w[j]),
      .div_o  (div_w[j+1]),
      .side_o (side_w[j+1])
    );
  end

  // stage 19: clamp and select
  logic [31:0] dep_d, dep_q;
  logic [15:0] alb_d, alb_q;
  logic [15:0] asy_d, asy_q;
  logic        last_q;
  logic        chk_v;
  div_t        df;
  side_t       sf;

  always_comb begin
    df    = div_w[QW];
    sf    = side_w[QW];
    dep_d = sf.depth;
    if (!sf.match) begin
      alb_d = sf.p_alb;
      asy_d = sf.p_asym;
    end else begin
      alb_d = (df.alb_q > ALB_ONE) ? ALB_ONE : df.alb_q;
      if (sf.neg) begin
        asy_d = (df.asy_q >= ALB_ONE) ? ALB_ONE : 16'(-df.asy_q);
      end else begin
        asy_d = (df.asy_q > ASYM_MAX) ? ASYM_MAX : df.asy_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NUM_STG-1]) begin
      dep_q  <= dep_d;
      alb_q  <= alb_d;
      asy_q  <= asy_d;
      last_q <= sf.last;
    end
  end

  assign valid_o      = v_q[NUM_STG-1];
  assign sum_depth_o  = dep_q;
  assign sum_albedo_o = alb_q;
  assign sum_asym_o   = $signed(asy_q);
  assign last_out_o   = last_q;

  assign chk_v = v_q[NUM_STG-2] && sf.match;

  `TSOC_ASSERT(a_stall_full, !stall_o || (v_q == '1), "stall with an empty stage")
  `TSOC_ASSERT(a_alb_rem, !chk_v || (df.alb_rem < {15'b0, df.alb_div}), "albedo rem too large")
  `TSOC_ASSERT(a_asy_rem, !chk_v || (df.asy_rem < {15'b0, df.asy_div}), "asym rem too large")
  `TSOC_ASSERT_NEXT(a_out_hold, valid_o && stall_i, valid_o && $stable(sum_depth_o) && $stable(last_out_o), "stalled result changed")

endmodule

// ----- tb/two_stream_optics_combine_top_test.sv -----
// Testbench for two_stream_optics_combine_top: random and directed optics transactions,
// results predicted in a scoreboard class and compared in order.
// Depends on tsoc_pkg and the combiner RTL.
`timescale 1ns / 1ps

class optics_scoreboard;
  typedef struct packed {
    logic [31:0] depth;
    logic [15:0] albedo;
    logic [15:0] asym;
    logic        last;
  } optics_res_t;

  optics_res_t pending_q[$];
  int unsigned errors;

  function logic [15:0] clip_alb(logic [15:0] a);
    return (a > tsoc_pkg::ALB_ONE) ? tsoc_pkg::ALB_ONE : a;
  endfunction

  function void note_input(logic [31:0] pd, logic [15:0] pa, logic [15:0] pg,
                           logic [31:0] bd, logic [15:0] ba, logic [15:0] bg,
                           logic match, logic last);
    optics_res_t r;
    logic [32:0] tsum;
    longint s1, s2, s, dd, num, q;
    r.last = last;
    if (!match) begin
      r.depth = pd; r.albedo = pa; r.asym = pg;
    end else begin
      tsum = {1'b0, pd} + {1'b0, bd};
      s1 = longint'(pd) * longint'(clip_alb(pa));
      s2 = longint'(bd) * longint'(clip_alb(ba));
      s = s1 + s2;
      dd = (tsum == 0) ? 1 : longint'(tsum);
      r.depth = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
      q = s / dd;
      r.albedo = (q > 32768) ? tsoc_pkg::ALB_ONE : q[15:0];
      num = s1 * longint'($signed(pg)) + s2 * longint'($signed(bg));
      q = num / ((s == 0) ? 1 : s);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      r.asym = q[15:0];
    end
    pending_q.push_back(r);
  endfunction

  function void check_result(logic [31:0] d, logic [15:0] a, logic [15:0] g, logic l);
    optics_res_t e;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result depth=%h albedo=%h asym=%h", $time, d, a, g);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (d !== e.depth) begin
      $display("%0t: depth expected %h actual %h", $time, e.depth, d); errors++;
    end
    if (a !== e.albedo) begin
      $display("%0t: albedo expected %h actual %h", $time, e.albedo, a); errors++;
    end
    if (g !== e.asym) begin
      $display("%0t: asym expected %h actual %h", $time, e.asym, g); errors++;
    end
    if (l !== e.last) begin
      $display("%0t: last expected %b actual %b", $time, e.last, l); errors++;
    end
  endfunction
endclass

module two_stream_optics_combine_top_test;
  import tsoc_pkg::*;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic valid_i = 1'b0, stall_i = 1'b0;
  logic stall_o, valid_o, last_out_o;
  logic [31:0] point_depth_i = '0, band_depth_i = '0, sum_depth_o;
  logic [15:0] point_albedo_i = '0, band_albedo_i = '0, sum_albedo_o;
  logic signed [15:0] point_asym_i = '0, band_asym_i = '0, sum_asym_o;
  logic band_match_i = 1'b0, last_item_i = 1'b0;

  int unsigned send_idle = 0, recv_stall = 0, idle_cycles = 0;
  optics_scoreboard optics_sb = new();

  two_stream_optics_combine_top dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    stall_i <= ($urandom_range(99) < recv_stall);
    if (rst_ni && valid_o && !stall_i)
      optics_sb.check_result(sum_depth_o, sum_albedo_o, sum_asym_o, last_out_o);
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 20000) begin
      $display("two_stream_optics_combine_top_test: done, errors");
      $finish;
    end
  end

  function automatic logic [31:0] rand_depth();
    case ($urandom_range(4))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF - $urandom_range(3);
      2: return $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_alb();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return ALB_ONE;
      2: return 16'($urandom);
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  task automatic send_item(logic [31:0] pd, logic [15:0] pa, logic [15:0] pg,
                           logic [31:0] bd, logic [15:0] ba, logic [15:0] bg,
                           logic m, logic l);
    while ($urandom_range(99) < send_idle) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    point_depth_i <= pd; point_albedo_i <= pa; point_asym_i <= pg;
    band_depth_i <= bd; band_albedo_i <= ba; band_asym_i <= bg;
    band_match_i <= m; last_item_i <= l;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    optics_sb.note_input(pd, pa, pg, bd, ba, bg, m, l);
  endtask

  task automatic send_random();
    send_item(rand_depth(), rand_alb(), 16'($urandom), rand_depth(), rand_alb(),
              16'($urandom), ($urandom_range(9) != 0), 1'($urandom_range(1)));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_item(32'd0, 16'd0, 16'd0, 32'd0, 16'd0, 16'd0, 1'b1, 1'b0);
    send_item(32'hFFFF_FFFF, ALB_ONE, 16'h7FFF, 32'hFFFF_FFFF, ALB_ONE, 16'h7FFF,
              1'b1, 1'b1);
    send_item(32'hFFFF_FFFF, 16'hFFFF, 16'h8000, 32'hFFFF_FFFF, 16'hFFFF, 16'h8000,
              1'b1, 1'b0);
    send_item(32'h1234_5678, 16'hFFFF, 16'h8000, 32'h0, 16'h0, 16'h0, 1'b0, 1'b1);
    send_item(32'h0001_0000, 16'd0, 16'h7FFF, 32'h0002_0000, 16'd0, 16'h8000, 1'b1, 1'b0);
    send_item(32'd0, ALB_ONE, 16'h4000, 32'd0, ALB_ONE, 16'hC000, 1'b1, 1'b0);
    send_item(32'd1, ALB_ONE, 16'h7FFF, 32'd0, 16'd0, 16'h8000, 1'b1, 1'b0);
    send_item(32'h0001_0000, 16'h4000, 16'h2000, 32'h0003_0000, 16'h9000, 16'hE000,
              1'b1, 1'b1);
    send_item(32'hFFFF_FFFF, 16'd0, 16'd0, 32'd0, 16'd0, 16'd0, 1'b0, 1'b0);
    valid_i <= 1'b0;
    while (optics_sb.pending_q.size() != 0) @(posedge clk_i);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? ((ph == 1) ? 81 : 14) : 0;
      recv_stall = (ph == 2) ? 81 : ((ph == 3) ? 14 : 0);
      for (int n = 0; n < 400; n++) send_random();
    end
    valid_i <= 1'b0;
    while (optics_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (optics_sb.errors == 0 && optics_sb.pending_q.size() == 0)
      $display("two_stream_optics_combine_top_test: done, clean");
    else
      $display("two_stream_optics_combine_top_test: done, errors");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+src
src/tsoc_pkg.sv
src/tsoc_div_stage.sv
src/two_stream_optics_combine_top.sv
tb/two_stream_optics_combine_top_test.sv
